FILE: src/sm83x_pkg.sv
// Shared types, opcode classes and helpers for the SM83 low-opcode executor.
package sm83x_pkg;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] imm;
    logic [7:0]  mem_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [15:0] read_addr;
    logic [1:0]  write_kind;
    logic [15:0] write_addr;
    logic [15:0] write_data;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LD_NN_SP, OP_JR, OP_LD_RR_NN, OP_ADD_HL, OP_LD_IND,
    OP_INC_RR, OP_DEC_RR, OP_INCDEC_R, OP_INCDEC_M, OP_LD_R_N, OP_LD_M_N,
    OP_ROT, OP_CPL, OP_SCF_CCF, OP_LD_R_R
  } op_class_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_BYTE = 2'd1,
    WR_WORD = 2'd2
  } write_kind_e;

  // Decoded transaction passed from front to back.
  typedef struct packed {
    op_class_e   cls;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [1:0]  len;
    logic [15:0] imm;
    logic [7:0]  mem_data;
  } dec_item_t;

  localparam int unsigned QDepth = 2;
  localparam logic [7:0] ByteMax = 8'hFF;
  localparam logic [3:0] NibMax = 4'hF;

  function automatic op_class_e classify(input logic [6:0] op);
    op_class_e c;
    logic [2:0] col;
    logic [2:0] row;
    col = op[2:0];
    row = op[5:3];
    c = OP_NOP;
    if (op[6]) begin
      c = (op >= 7'h60) ? OP_NOP : OP_LD_R_R;
    end else begin
      case (col)
        3'd0: c = (row == 3'd1) ? OP_LD_NN_SP : ((row >= 3'd3) ? OP_JR : OP_NOP);
        3'd1: c = row[0] ? OP_ADD_HL : OP_LD_RR_NN;
        3'd2: c = OP_LD_IND;
        3'd3: c = row[0] ? OP_DEC_RR : OP_INC_RR;
        3'd4, 3'd5: c = (row == 3'd6) ? OP_INCDEC_M : OP_INCDEC_R;
        3'd6: c = (row == 3'd6) ? OP_LD_M_N : OP_LD_R_N;
        default: begin
          if (row < 3'd4) c = OP_ROT;
          else if (row == 3'd5) c = OP_CPL;
          else if (row >= 3'd6) c = OP_SCF_CCF;
          else c = OP_NOP;
        end
      endcase
    end
    return c;
  endfunction

  function automatic logic [1:0] op_len(input op_class_e c);
    logic [1:0] l;
    case (c)
      OP_LD_NN_SP, OP_LD_RR_NN: l = 2'd3;
      OP_JR, OP_LD_R_N, OP_LD_M_N: l = 2'd2;
      default: l = 2'd1;
    endcase
    return l;
  endfunction

endpackage

FILE: src/sm83x_front.sv
// Front end: accepts instructions, classifies them and queues them for execution.
module sm83x_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sm83x_pkg::in_item_t  in_data,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output sm83x_pkg::dec_item_t q_data_o
);

  localparam int unsigned PtrW = $clog2(sm83x_pkg::QDepth);

  sm83x_pkg::dec_item_t mem_q [sm83x_pkg::QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;
  sm83x_pkg::dec_item_t dec;

  always_comb begin
    dec.cls      = sm83x_pkg::classify(in_data.kind);
    dec.row      = in_data.kind[5:3];
    dec.col      = in_data.kind[2:0];
    dec.len      = sm83x_pkg::op_len(dec.cls);
    dec.imm      = in_data.imm;
    dec.mem_data = in_data.mem_data;
  end

  assign in_stall  = (cnt_q == (PtrW+1)'(sm83x_pkg::QDepth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = q_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= dec;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(sm83x_pkg::QDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

FILE: src/sm83x_back.sv
// Back end: executes decoded instructions against the register file.
module sm83x_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  sm83x_pkg::dec_item_t q_data_i,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sm83x_pkg::out_item_t out_data
);

  logic [7:0]  a_q, a_d;
  logic [3:0]  f_q, f_d;
  logic [15:0] bc_q, bc_d, de_q, de_d, hl_q, hl_d, sp_q, sp_d, pc_q, pc_d;
  logic        ov_q;
  sm83x_pkg::out_item_t o_q, o_d;
  logic        fire;

  assign q_pop_o   = q_valid_i && (!ov_q || !out_stall);
  assign fire      = q_pop_o;
  assign out_valid = ov_q;
  assign out_data  = o_q;

  always_comb begin
    logic [2:0]  row, col;
    logic [7:0]  n, src, r8;
    logic [15:0] pr, addr, nxt;
    logic [16:0] sum;
    logic        jump, cy;
    row = q_data_i.row;
    col = q_data_i.col;
    n   = q_data_i.imm[7:0];
    a_d = a_q; f_d = f_q; bc_d = bc_q; de_d = de_q; hl_d = hl_q; sp_d = sp_q;
    jump = 1'b0; src = '0; r8 = '0; sum = '0; cy = 1'b0;
    o_d.read_addr  = '0;
    o_d.write_kind = sm83x_pkg::WR_NONE;
    o_d.write_addr = '0;
    o_d.write_data = '0;
    case (row[2:1])
      2'd0: pr = bc_q;
      2'd1: pr = de_q;
      2'd2: pr = hl_q;
      default: pr = sp_q;
    endcase
    addr = (row < 3'd2) ? bc_q : ((row < 3'd4) ? de_q : hl_q);
    // 8-bit source register by column (for LD r,r) or by row (INC/DEC r)
    case ((q_data_i.cls == sm83x_pkg::OP_LD_R_R) ? col : row)
      3'd0: src = bc_q[15:8];
      3'd1: src = bc_q[7:0];
      3'd2: src = de_q[15:8];
      3'd3: src = de_q[7:0];
      3'd4: src = hl_q[15:8];
      3'd5: src = hl_q[7:0];
      3'd7: src = a_q;
      default: src = '0;
    endcase
    case (q_data_i.cls)
      sm83x_pkg::OP_LD_NN_SP: begin
        o_d.write_kind = sm83x_pkg::WR_WORD;
        o_d.write_addr = q_data_i.imm;
        o_d.write_data = sp_q;
      end
      sm83x_pkg::OP_JR: begin
        case (row)
          3'd3: jump = 1'b1;
          3'd4: jump = !f_q[3];
          3'd5: jump = f_q[3];
          3'd6: jump = !f_q[0];
          default: jump = f_q[0];
        endcase
      end
      sm83x_pkg::OP_LD_RR_NN: begin
        case (row[2:1])
          2'd0: bc_d = q_data_i.imm;
          2'd1: de_d = q_data_i.imm;
          2'd2: hl_d = q_data_i.imm;
          default: sp_d = q_data_i.imm;
        endcase
      end
      sm83x_pkg::OP_ADD_HL: begin
        sum  = {1'b0, hl_q} + {1'b0, pr};
        hl_d = sum[15:0];
        f_d[2] = 1'b0;
        f_d[1] = ({1'b0, hl_q[11:0]} + {1'b0, pr[11:0]}) > 13'h0FFF;
        f_d[0] = sum[16];
      end
      sm83x_pkg::OP_LD_IND: begin
        if (row[0]) begin
          o_d.read_addr = addr;
          a_d = q_data_i.mem_data;
        end else begin
          o_d.write_kind = sm83x_pkg::WR_BYTE;
          o_d.write_addr = addr;
          o_d.write_data = {8'h00, a_q};
        end
        if (row >= 3'd6) hl_d = hl_q - 16'd1;
        else if (row >= 3'd4) hl_d = hl_q + 16'd1;
      end
      sm83x_pkg::OP_INC_RR, sm83x_pkg::OP_DEC_RR: begin
        nxt = (q_data_i.cls == sm83x_pkg::OP_DEC_RR) ? pr - 16'd1 : pr + 16'd1;
        case (row[2:1])
          2'd0: bc_d = nxt;
          2'd1: de_d = nxt;
          2'd2: hl_d = nxt;
          default: sp_d = nxt;
        endcase
      end
      sm83x_pkg::OP_INCDEC_R, sm83x_pkg::OP_INCDEC_M: begin
        if (q_data_i.cls == sm83x_pkg::OP_INCDEC_M) src = q_data_i.mem_data;
        r8 = col[0] ? src - 8'd1 : src + 8'd1;
        f_d[3] = (r8 == 8'd0);
        f_d[2] = col[0];
        f_d[1] = col[0] ? (r8[3:0] == sm83x_pkg::NibMax) : (r8[3:0] == 4'd0);
        if (q_data_i.cls == sm83x_pkg::OP_INCDEC_M) begin
          o_d.read_addr  = hl_q;
          o_d.write_kind = sm83x_pkg::WR_BYTE;
          o_d.write_addr = hl_q;
          o_d.write_data = {8'h00, r8};
        end
      end
      sm83x_pkg::OP_LD_R_N: r8 = n;
      sm83x_pkg::OP_LD_M_N: begin
        o_d.write_kind = sm83x_pkg::WR_BYTE;
        o_d.write_addr = hl_q;
        o_d.write_data = {8'h00, n};
      end
      sm83x_pkg::OP_ROT: begin
        cy = row[0] ? a_q[0] : a_q[7];
        case (row[1:0])
          2'd0: a_d = {a_q[6:0], a_q[7]};
          2'd1: a_d = {a_q[0], a_q[7:1]};
          2'd2: a_d = {a_q[6:0], f_q[0]};
          default: a_d = {f_q[0], a_q[7:1]};
        endcase
        f_d = {3'b000, cy};
      end
      sm83x_pkg::OP_CPL: begin
        a_d = a_q ^ sm83x_pkg::ByteMax;
        f_d[2] = 1'b1;
        f_d[1] = 1'b1;
      end
      sm83x_pkg::OP_SCF_CCF: begin
        f_d[2] = 1'b0;
        f_d[1] = 1'b0;
        f_d[0] = row[0] ? !f_q[0] : 1'b1;
      end
      sm83x_pkg::OP_LD_R_R: begin
        r8 = (col == 3'd6) ? q_data_i.mem_data : src;
        if (col == 3'd6) o_d.read_addr = hl_q;
      end
      default: ;
    endcase
    // 8-bit register destination writes
    if (q_data_i.cls == sm83x_pkg::OP_INCDEC_R || q_data_i.cls == sm83x_pkg::OP_LD_R_N
        || q_data_i.cls == sm83x_pkg::OP_LD_R_R) begin
      case ((q_data_i.cls == sm83x_pkg::OP_LD_R_R) ? {1'b0, row[1:0]} : row)
        3'd0: bc_d[15:8] = r8;
        3'd1: bc_d[7:0]  = r8;
        3'd2: de_d[15:8] = r8;
        3'd3: de_d[7:0]  = r8;
        3'd4: hl_d[15:8] = r8;
        3'd5: hl_d[7:0]  = r8;
        3'd7: a_d        = r8;
        default: ;
      endcase
    end
    nxt  = pc_q + {14'd0, q_data_i.len};
    pc_d = jump ? nxt + {{8{n[7]}}, n} : nxt;
    o_d.af = {a_d, f_d, 4'h0};
    o_d.bc = bc_d;
    o_d.de = de_d;
    o_d.hl = hl_d;
    o_d.sp = sp_d;
    o_d.pc = pc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; f_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0;
      sp_q <= '0; pc_q <= '0; ov_q <= 1'b0;
    end else begin
      if (fire) begin
        a_q <= a_d; f_q <= f_d; bc_q <= bc_d; de_q <= de_d; hl_q <= hl_d;
        sp_q <= sp_d; pc_q <= pc_d;
      end
      if (fire) ov_q <= 1'b1;
      else if (!out_stall) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) o_q <= o_d;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall) |-> !q_pop_o) else $error("overwrote stalled result");
  a_pc_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pc_q)) else $error("pc changed without transaction");
  a_af_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> o_q.af[3:0] == 4'h0) else $error("flag low nibble set");

endmodule

FILE: src/sm83_low_opcode_executor_core.sv
// Top level of the SM83 low-opcode executor: front decode, queue, back execute.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_data  (kind, imm, mem_data)
//   out     | out | out_valid/out_stall| out_data (registers, read/write info)
//
// One instruction per cycle sustained while the output is not stalled; an accepted
// instruction is written into the queue, then executed into the output register.
// The register file update is the back-end step that sets the rate.
// Reset clears all registers, the queue and the output valid.
// A stalled output holds; the two-entry queue keeps taking input until full.
module sm83_low_opcode_executor_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sm83x_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sm83x_pkg::out_item_t out_data
);

  logic                 q_valid, q_pop;
  sm83x_pkg::dec_item_t q_data;

  sm83x_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  sm83x_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
